// File: src/median_of_samples_defines.svh
// Assertion helpers used by the block's top-level module.
`ifndef MEDIAN_OF_SAMPLES_DEFINES_SVH
`define MEDIAN_OF_SAMPLES_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define MOS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: same-cycle implication");

// Check that an antecedent implies a consequent in the next cycle.
`define MOS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

// Check that a condition holds on every clock edge out of reset.
`define MOS_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed: invariant");

`endif

// File: src/mos_pkg.sv
package mos_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_W    = 16;
  localparam int MED_W       = 17;
  localparam int OUT_CNT_W   = 7;
  localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int LEAF_W      = 3;
  localparam int LEAVES      = 2 ** LEAF_W;
  localparam int GRP_W       = (IDX_W > LEAF_W) ? (IDX_W - LEAF_W) : 1;
  localparam int GROUPS      = 2 ** GRP_W;
  localparam int SEL_W       = LEAF_W + GRP_W;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } samp_t;

  typedef struct packed {
    logic [MED_W-1:0]     median_doubled;
    logic [OUT_CNT_W-1:0] sample_count;
    logic                 overflow;
  } res_t;

  typedef struct packed {
    logic                load;
    logic [SAMPLE_W-1:0] value;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEL,
    ST_SUM
  } st_t;

endpackage

// File: src/mos_cell.sv
module mos_cell (
  input  logic                          clk,
  input  mos_pkg::cell_ctl_t            ctl,
  input  logic                          occ,
  input  logic                          prev_gt,
  input  logic [mos_pkg::SAMPLE_W-1:0]  prev_val,
  output logic                          gt,
  output logic [mos_pkg::SAMPLE_W-1:0]  val
);
  import mos_pkg::*;

  logic [SAMPLE_W-1:0] val_next;

  assign gt = occ && (val > ctl.value);

  always_comb begin
    priority if (occ && !gt) begin
      val_next = val;
    end else if (prev_gt) begin
      val_next = prev_val;
    end else begin
      val_next = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= val_next;
    end
  end

endmodule

// File: src/mos_chain.sv
module mos_chain (
  input  logic                          clk,
  input  mos_pkg::cell_ctl_t            ctl,
  input  logic [mos_pkg::COUNT_W-1:0]   count,
  output logic [mos_pkg::SAMPLE_W-1:0]  vals [mos_pkg::MAX_SAMPLES]
);
  import mos_pkg::*;

  logic gt [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic                occ;
    logic                prev_gt;
    logic [SAMPLE_W-1:0] prev_val;

    assign occ = count > COUNT_W'(i);

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_gt  = gt[i-1];
      assign prev_val = vals[i-1];
    end

    mos_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .gt       (gt[i]),
      .val      (vals[i])
    );
  end

endmodule

// File: src/mos_select.sv
module mos_select (
  input  logic                          clk,
  input  logic                          cap,
  input  logic [mos_pkg::COUNT_W-1:0]   count,
  input  logic [mos_pkg::SAMPLE_W-1:0]  vals [mos_pkg::MAX_SAMPLES],
  output logic [mos_pkg::MED_W-1:0]     sum
);
  import mos_pkg::*;

  logic [COUNT_W-1:0]  half;
  logic [IDX_W-1:0]    idx_hi;
  logic [IDX_W-1:0]    idx_lo;
  logic [SEL_W-1:0]    sel_hi;
  logic [SEL_W-1:0]    sel_lo;
  logic [SAMPLE_W-1:0] pick_hi [GROUPS];
  logic [SAMPLE_W-1:0] pick_lo [GROUPS];
  logic [SAMPLE_W-1:0] grp_hi  [GROUPS];
  logic [SAMPLE_W-1:0] grp_lo  [GROUPS];
  logic [GRP_W-1:0]    gsel_hi;
  logic [GRP_W-1:0]    gsel_lo;

  assign half   = count >> 1;
  assign idx_hi = IDX_W'(half);
  assign idx_lo = count[0] ? IDX_W'(half) : IDX_W'(half - COUNT_W'(1));
  assign sel_hi = SEL_W'(idx_hi);
  assign sel_lo = SEL_W'(idx_lo);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      pick_hi[g] = '0;
      pick_lo[g] = '0;
      for (int j = 0; j < LEAVES; j++) begin
        if (g * LEAVES + j < MAX_SAMPLES) begin
          if (sel_hi[LEAF_W-1:0] == LEAF_W'(j)) begin
            pick_hi[g] = vals[g * LEAVES + j];
          end
          if (sel_lo[LEAF_W-1:0] == LEAF_W'(j)) begin
            pick_lo[g] = vals[g * LEAVES + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      grp_hi  <= pick_hi;
      grp_lo  <= pick_lo;
      gsel_hi <= sel_hi[SEL_W-1:LEAF_W];
      gsel_lo <= sel_lo[SEL_W-1:LEAF_W];
    end
  end

  assign sum = MED_W'(grp_hi[gsel_hi]) + MED_W'(grp_lo[gsel_lo]);

endmodule

// File: src/median_of_samples.sv
// Median of a set of unsigned 16-bit samples. Each accepted item inserts its
// sample into a sorted chain of 64 cells while the chain has room; the item
// with last set closes the set and yields one result: twice the median (one
// fraction bit), the number of samples kept and an overflow flag for samples
// dropped once the chain was full. Samples are taken one per cycle while a set
// loads. After the closing item the input stalls while a two-level registered
// mux tree reads the middle cells and adds them (ST_SEL, then ST_SUM, which
// holds while an older result is stalled); a finished result waits in the
// output register while the next set loads.
`include "median_of_samples_defines.svh"

module median_of_samples (
  input  logic           clk,
  input  logic           rst,
  input  logic           samp_valid,
  output logic           samp_stall,
  input  mos_pkg::samp_t samp,
  output logic           res_valid,
  input  logic           res_stall,
  output mos_pkg::res_t  res
);
  import mos_pkg::*;

  st_t                 state;
  st_t                 state_next;
  logic [COUNT_W-1:0]  count;
  logic                dropped;
  logic [COUNT_W-1:0]  fin_count;
  logic                fin_ovf;
  logic                accept;
  logic                full;
  logic                sel_cap;
  logic                res_load;
  logic [MED_W-1:0]    sum;
  logic [SAMPLE_W-1:0] vals [MAX_SAMPLES];
  cell_ctl_t           ctl;

  assign accept = samp_valid && !samp_stall;
  assign full   = count == COUNT_W'(MAX_SAMPLES);

  assign ctl.load  = accept && !full;
  assign ctl.value = samp.sample;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && samp.last) begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        if (!res_valid || !res_stall) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    samp_stall = 1'b1;
    sel_cap    = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        samp_stall = 1'b0;
      end
      ST_SEL: begin
        sel_cap = 1'b1;
      end
      ST_SUM: begin
        res_load = !res_valid || !res_stall;
      end
      default: begin
        samp_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (samp.last) begin
          count   <= '0;
          dropped <= 1'b0;
        end else if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && samp.last) begin
      fin_count <= full ? count : count + COUNT_W'(1);
      fin_ovf   <= dropped || full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.median_doubled <= sum;
      res.sample_count   <= OUT_CNT_W'(fin_count);
      res.overflow       <= fin_ovf;
    end
  end

  mos_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count),
    .vals  (vals)
  );

  mos_select u_select (
    .clk   (clk),
    .cap   (sel_cap),
    .count (fin_count),
    .vals  (vals),
    .sum   (sum)
  );

  `MOS_ASSERT_NEXT(a_clear_after_last, accept && samp.last, count == '0 && !dropped)
  `MOS_ASSERT_ALWAYS(a_count_bound, count <= COUNT_W'(MAX_SAMPLES))
  `MOS_ASSERT_SAME(a_result_from_sum, $rose(res_valid), $past(state) == ST_SUM)
  `MOS_ASSERT_NEXT(a_sel_then_sum, state == ST_SEL, state == ST_SUM)

endmodule
